### sv/vpp_pkg.sv
package vpp_pkg;

    // Fixed-point format of coordinates and matrix coefficients.
    localparam int COORD_FRAC_BITS = 12;
    localparam int COORD_W         = 16;
    localparam int NUM_LANES       = 3;
    localparam int NUM_COLS        = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_W * NUM_LANES;
    localparam int DIM_W      = 12;

    localparam logic [CFG_IDX_W-1:0] REG_BASIS_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BIAS    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = CFG_IDX_W'(5);

    localparam int COORD_ONE = 1 << COORD_FRAC_BITS;
    localparam logic [CFG_DATA_W-1:0] BASIS_X_RESET = CFG_DATA_W'(COORD_ONE);
    localparam logic [CFG_DATA_W-1:0] BASIS_Y_RESET = CFG_DATA_W'(COORD_ONE) << COORD_W;
    localparam logic [CFG_DATA_W-1:0] BASIS_Z_RESET = CFG_DATA_W'(COORD_ONE) << (2 * COORD_W);
    localparam logic [CFG_DATA_W-1:0] BIAS_RESET    =
        CFG_DATA_W'(3 * COORD_ONE) << (2 * COORD_W);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

    // Datapath widths.
    localparam int PROD_W = 2 * COORD_W;          // one coefficient times one coordinate
    localparam int SUM_W  = PROD_W + 2;           // three products plus the shifted bias
    localparam int DEP_W  = SUM_W - 1;            // floored depth, always positive
    localparam int SCL_W  = SUM_W + DIM_W;        // signed coordinate times display size
    localparam int WD_W   = DEP_W + DIM_W;        // depth times display size
    localparam int NUM_W  = SCL_W + 1;            // numerator of the final division
    localparam int MAG_W  = NUM_W - 1;            // numerator magnitude
    localparam int DEN_W  = DEP_W + 1;            // twice the depth
    localparam int PIX_W  = 16;
    localparam int Q_W    = PIX_W;                // quotient bits resolved by the divider
    localparam int REM_W  = DEN_W + Q_W;

    // Depth floor: 0.01 in coordinate format, then scaled to the product format.
    localparam int DMIN = (COORD_ONE + 50) / 100;
    localparam logic signed [SUM_W-1:0] DEPTH_FLOOR = SUM_W'(DMIN * COORD_ONE);

    // Divider pipeline shape.
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = Q_W / DIV_STEPS;

    // Pipeline stage numbering.
    localparam int ST_PROD    = 0;
    localparam int ST_SUM     = 1;
    localparam int ST_SCALE   = 2;
    localparam int ST_NUM     = 3;
    localparam int ST_ABS     = 4;
    localparam int ST_DIV0    = 5;
    localparam int ST_OUT     = ST_DIV0 + DIV_STAGES;
    localparam int NUM_STAGES = ST_OUT + 1;

    // Saturation limits.
    localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};
    localparam logic [Q_W-1:0] PIX_MIN_MAG      = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } vpp_vertex_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
    } vpp_pixel_t;

endpackage

### sv/vertex_perspective_projection.sv
// Vertex perspective projection.
// A vertex transaction on vertex/vertex_valid/vertex_ready carries one point in
// signed Q4.12. It is multiplied by the configured 3x4 model-view matrix, its
// depth is floored at 0.01, and the aspect-corrected, depth-divided and
// viewport-scaled screen position leaves as a pixel transaction on
// pixel/pixel_valid/pixel_ready, truncated toward zero and saturated to 16 bits.
// The matrix and display size are written through cfg_write/cfg_index/cfg_data,
// one register per cycle. The user must write them only while no vertex is in
// flight; the block itself does not enforce this.
// The pipeline has 14 register stages: products, sums and depth floor, size
// scaling, numerator add, magnitude, eight divider stages that each resolve
// two quotient bits, and the output register. Throughput is one vertex per
// cycle while pixel_ready is high, set by that fully pipelined divider.
// Reset clears every stage valid bit and loads the default matrix (identity
// with a depth bias of 3.0) and a 16 by 16 display.
// When the receiver stalls, each stage holds only if the one after it is full,
// so bubbles close up and vertices are still taken until the pipeline is full.
module vertex_perspective_projection (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              vertex_valid,
    output logic                              vertex_ready,
    input  vpp_pkg::vpp_vertex_t              vertex,
    output logic                              pixel_valid,
    input  logic                              pixel_ready,
    output vpp_pkg::vpp_pixel_t               pixel,
    input  logic                              cfg_write,
    input  logic [vpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vpp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import vpp_pkg::*;

    // One divider lane: partial remainder, quotient bits so far, sign, and a
    // flag for a quotient too large for the pixel range.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             neg;
        logic             ov;
    } lane_t;

    // Restoring division, DIV_STEPS quotient bits starting at bit top.
    function automatic lane_t lane_steps(lane_t a, logic [DEN_W-1:0] den, int top);
        lane_t            r;
        logic [REM_W-1:0] trial;
        logic             take;
        r = a;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial = REM_W'(den) << (top - k);
            take  = (r.rem >= trial);
            if (take)
            begin
                r.rem = r.rem - trial;
            end
            r.q = {r.q[Q_W-2:0], take};
        end
        return r;
    endfunction

    function automatic logic signed [PIX_W-1:0] sat_lane(lane_t a);
        logic signed [PIX_W-1:0] r;
        if (a.ov)
        begin
            r = a.neg ? PIX_MIN : PIX_MAX;
        end
        else if (a.neg)
        begin
            r = (a.q > PIX_MIN_MAG) ? PIX_MIN : $signed(~a.q + Q_W'(1));
        end
        else
        begin
            r = a.q[Q_W-1] ? PIX_MAX : $signed(a.q);
        end
        return r;
    endfunction

    // Configuration registers.
    logic [CFG_DATA_W-1:0] basis_x_reg;
    logic [CFG_DATA_W-1:0] basis_y_reg;
    logic [CFG_DATA_W-1:0] basis_z_reg;
    logic [CFG_DATA_W-1:0] bias_col_reg;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;

    // Handshake control: one valid bit and one enable per stage.
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;

    // Stage registers and their next values.
    logic signed [PROD_W-1:0]  prod_reg  [NUM_LANES][NUM_COLS];
    logic signed [PROD_W-1:0]  prod_next [NUM_LANES][NUM_COLS];
    logic signed [COORD_W-1:0] bias_reg  [NUM_LANES];
    logic signed [COORD_W-1:0] bias_next [NUM_LANES];

    logic signed [SUM_W-1:0] x_sum_reg, x_sum_next;
    logic signed [SUM_W-1:0] y_sum_reg, y_sum_next;
    logic [DEP_W-1:0]        depth_reg, depth_next;

    logic signed [SCL_W-1:0] xs_reg, xs_next;
    logic signed [SCL_W-1:0] ys_reg, ys_next;
    logic [WD_W-1:0]         wd_reg, wd_next;
    logic [WD_W-1:0]         hd_reg, hd_next;
    logic [DEN_W-1:0]        den2_reg, den2_next;

    logic signed [NUM_W-1:0] nx_reg, nx_next;
    logic signed [NUM_W-1:0] ny_reg, ny_next;
    logic [DEN_W-1:0]        den3_reg;

    logic [MAG_W-1:0] mag_x_reg, mag_x_next;
    logic [MAG_W-1:0] mag_y_reg, mag_y_next;
    logic             neg_x_reg, neg_x_next;
    logic             neg_y_reg, neg_y_next;
    logic [DEN_W-1:0] den4_reg;

    lane_t            lx_reg   [DIV_STAGES];
    lane_t            lx_next  [DIV_STAGES];
    lane_t            ly_reg   [DIV_STAGES];
    lane_t            ly_next  [DIV_STAGES];
    logic [DEN_W-1:0] dden_reg [DIV_STAGES];

    vpp_pixel_t pixel_reg, pixel_next;

    // Combinational helpers.
    logic [CFG_DATA_W-1:0]     cols [NUM_COLS];
    logic signed [COORD_W-1:0] pt   [NUM_COLS];
    logic signed [SUM_W-1:0]   sum  [NUM_LANES];
    logic [DIM_W-1:0]          s_min;
    logic signed [DIM_W:0]     s_sgn;
    logic signed [SCL_W:0]     xs_full;
    logic signed [SCL_W:0]     ys_full;
    logic signed [NUM_W-1:0]   abs_x;
    logic signed [NUM_W-1:0]   abs_y;
    lane_t                     init_x;
    lane_t                     init_y;
    logic                      ov_x;
    logic                      ov_y;

    // ---------------------------------------------------------------------
    // Configuration writes. Unknown indexes are ignored.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_x_reg  <= BASIS_X_RESET;
            basis_y_reg  <= BASIS_Y_RESET;
            basis_z_reg  <= BASIS_Z_RESET;
            bias_col_reg <= BIAS_RESET;
            width_reg    <= DIM_RESET;
            height_reg   <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BASIS_X: basis_x_reg  <= cfg_data;
                REG_BASIS_Y: basis_y_reg  <= cfg_data;
                REG_BASIS_Z: basis_z_reg  <= cfg_data;
                REG_BIAS:    bias_col_reg <= cfg_data;
                REG_WIDTH:   width_reg    <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:  height_reg   <= cfg_data[DIM_W-1:0];
                default:     ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Stage enables. A stage loads when it is empty or when the stage after
    // it moves on; the output stage moves on when the pixel is taken.
    // ---------------------------------------------------------------------
    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || pixel_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign vertex_ready = en[ST_PROD];
    assign pixel_valid  = v_reg[ST_OUT];
    assign pixel        = pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[ST_PROD])
            begin
                v_reg[ST_PROD] <= vertex_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Datapath.
    // ---------------------------------------------------------------------
    always_comb
    begin
        // Stage 0: the nine coefficient-by-coordinate products.
        cols[0] = basis_x_reg;
        cols[1] = basis_y_reg;
        cols[2] = basis_z_reg;
        pt[0]   = vertex.point_x;
        pt[1]   = vertex.point_y;
        pt[2]   = vertex.point_z;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                prod_next[k][c] = $signed(cols[c][k*COORD_W +: COORD_W]) * pt[c];
            end
            bias_next[k] = $signed(bias_col_reg[k*COORD_W +: COORD_W]);
        end

        // Stage 1: row sums, exact with twice the fraction bits, and the
        // depth floor that keeps the divisor positive.
        for (int k = 0; k < NUM_LANES; k++)
        begin
            sum[k] = SUM_W'(prod_reg[k][0]) + SUM_W'(prod_reg[k][1])
                   + SUM_W'(prod_reg[k][2])
                   + SUM_W'($signed({bias_reg[k], {COORD_FRAC_BITS{1'b0}}}));
        end
        x_sum_next = sum[0];
        y_sum_next = sum[1];
        depth_next = (sum[2] < DEPTH_FLOOR) ? DEPTH_FLOOR[DEP_W-1:0] : sum[2][DEP_W-1:0];

        // Stage 2: aspect and viewport scaling. The numerator of each axis is
        // coordinate * min(W,H) + size * depth, over twice the depth.
        s_min     = (width_reg > height_reg) ? height_reg : width_reg;
        s_sgn     = $signed({1'b0, s_min});
        xs_full   = x_sum_reg * s_sgn;
        ys_full   = y_sum_reg * s_sgn;
        xs_next   = xs_full[SCL_W-1:0];
        ys_next   = ys_full[SCL_W-1:0];
        wd_next   = depth_reg * width_reg;
        hd_next   = depth_reg * height_reg;
        den2_next = {depth_reg, 1'b0};

        // Stage 3: numerators.
        nx_next = NUM_W'(xs_reg) + $signed({2'b00, wd_reg});
        ny_next = NUM_W'(ys_reg) + $signed({2'b00, hd_reg});

        // Stage 4: sign and magnitude, so the divider works unsigned and the
        // quotient truncates toward zero.
        neg_x_next = nx_reg[NUM_W-1];
        neg_y_next = ny_reg[NUM_W-1];
        abs_x      = neg_x_next ? -nx_reg : nx_reg;
        abs_y      = neg_y_next ? -ny_reg : ny_reg;
        mag_x_next = abs_x[MAG_W-1:0];
        mag_y_next = abs_y[MAG_W-1:0];

        // First divider stage also flags quotients of 2^16 or more, which
        // saturate whatever the low bits turn out to be.
        ov_x   = (REM_W'(mag_x_reg) >= (REM_W'(den4_reg) << Q_W));
        ov_y   = (REM_W'(mag_y_reg) >= (REM_W'(den4_reg) << Q_W));
        init_x = '{rem: REM_W'(mag_x_reg), q: '0, neg: neg_x_reg, ov: ov_x};
        init_y = '{rem: REM_W'(mag_y_reg), q: '0, neg: neg_y_reg, ov: ov_y};
        lx_next[0] = lane_steps(init_x, den4_reg, Q_W - 1);
        ly_next[0] = lane_steps(init_y, den4_reg, Q_W - 1);
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            lx_next[j] = lane_steps(lx_reg[j-1], dden_reg[j-1], Q_W - 1 - j * DIV_STEPS);
            ly_next[j] = lane_steps(ly_reg[j-1], dden_reg[j-1], Q_W - 1 - j * DIV_STEPS);
        end

        // Output stage: sign and saturation.
        pixel_next.pixel_x = sat_lane(lx_reg[DIV_STAGES-1]);
        pixel_next.pixel_y = sat_lane(ly_reg[DIV_STAGES-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            prod_reg <= prod_next;
            bias_reg <= bias_next;
        end
        if (en[ST_SUM])
        begin
            x_sum_reg <= x_sum_next;
            y_sum_reg <= y_sum_next;
            depth_reg <= depth_next;
        end
        if (en[ST_SCALE])
        begin
            xs_reg   <= xs_next;
            ys_reg   <= ys_next;
            wd_reg   <= wd_next;
            hd_reg   <= hd_next;
            den2_reg <= den2_next;
        end
        if (en[ST_NUM])
        begin
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            den3_reg <= den2_reg;
        end
        if (en[ST_ABS])
        begin
            mag_x_reg <= mag_x_next;
            mag_y_reg <= mag_y_next;
            neg_x_reg <= neg_x_next;
            neg_y_reg <= neg_y_next;
            den4_reg  <= den3_reg;
        end
        if (en[ST_DIV0])
        begin
            lx_reg[0]   <= lx_next[0];
            ly_reg[0]   <= ly_next[0];
            dden_reg[0] <= den4_reg;
        end
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            if (en[ST_DIV0 + j])
            begin
                lx_reg[j]   <= lx_next[j];
                ly_reg[j]   <= ly_next[j];
                dden_reg[j] <= dden_reg[j-1];
            end
        end
        if (en[ST_OUT])
        begin
            pixel_reg <= pixel_next;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------

    // An empty first stage always takes a new vertex.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[ST_PROD] |-> vertex_ready)
        else $error("first stage empty but vertex_ready low");

    // A vertex waiting behind a stalled output is held, not dropped.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_OUT-1] && pixel_valid && !pixel_ready |=> v_reg[ST_OUT-1])
        else $error("vertex lost behind a stalled pixel");

    // The divisor reaching the divider is never below twice the depth floor.
    a_den_floor: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_ABS] |-> (den4_reg >= {DEPTH_FLOOR[DEP_W-1:0], 1'b0}))
        else $error("divisor below the depth floor");

    // A positive overflowing quotient leaves as the largest pixel value.
    a_sat_high: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_OUT-1] && en[ST_OUT] && lx_reg[DIV_STAGES-1].ov
            && !lx_reg[DIV_STAGES-1].neg |=> pixel.pixel_x == PIX_MAX)
        else $error("overflowing pixel_x not saturated");

endmodule
